// ----- rtl/hru_pkg.sv -----
// Shared types, constants and helpers for the Hermitian rank-1 update block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package hru_pkg;

  // store depth, field widths
  localparam int MaxN   = 256;
  localparam int IdxW   = 8;
  localparam int LenW   = 9;
  localparam int CompW  = 16;

  // front-to-back queue and result queue
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam int ODepth = 4;
  localparam int OPtrW  = $clog2(ODepth);
  localparam int OCntW  = $clog2(ODepth + 1);

  // configuration register indexes
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPPER  = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_ALPHA  = 2'd2
  } cfg_reg_e;

  // item commands
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef logic signed [CompW-1:0] q15_t;

  typedef struct packed {
    q15_t re;
    q15_t im;
  } cplx_t;

  typedef struct packed {
    logic            upper;
    logic [LenW-1:0] length;
    q15_t            alpha;
  } cfg_t;

  // classified update item handed from front to back
  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    cplx_t           elem;
    cplx_t           x_row;
    cplx_t           x_col;
    logic            changed;
  } job_t;

  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    cplx_t           elem;
    logic            changed;
  } result_t;

  // clamp a wide signed value into Q1.15
  function automatic q15_t sat_q15(input logic signed [33:0] v);
    q15_t r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CompW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/hru_front.sv -----
// Front end: accepts items, holds the x store, classifies updates and reads
// both x entries. Depends on hru_pkg.
`timescale 1ns / 1ps

module hru_front import hru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             push,
  output logic             full,
  input  logic             command_i,
  input  logic [IdxW-1:0]  row_i,
  input  logic [IdxW-1:0]  col_i,
  input  q15_t             value_re_i,
  input  q15_t             value_im_i,
  input  logic [QCntW-1:0] q_count_i,
  output logic             q_push_o,
  output job_t             q_job_o
);

  cplx_t           x_mem [MaxN];
  logic            f1_valid_q;
  job_t            f1_job_q;
  logic            accept;
  logic            is_update;
  logic [LenW-1:0] n_eff;
  logic            in_range;
  logic            in_tri;
  logic            changed;

  // room is counted over the staging register and the queue
  assign full     = (q_count_i + QCntW'(f1_valid_q)) >= QCntW'(QDepth);
  assign accept   = push && !full;
  assign is_update = (cmd_e'(command_i) == CMD_UPDATE);

  // classify against triangle, order and alpha
  assign n_eff    = (cfg_i.length > LenW'(MaxN)) ? LenW'(MaxN) : cfg_i.length;
  assign in_range = ({1'b0, row_i} < n_eff) && ({1'b0, col_i} < n_eff);
  assign in_tri   = (row_i == col_i) ||
                    (cfg_i.upper ? (row_i < col_i) : (row_i > col_i));
  assign changed  = (cfg_i.alpha != '0) && in_range && in_tri;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept && is_update;
    end
  end

  // x store write and registered reads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!is_update) begin
        if (int'(row_i) < MaxN) begin
          x_mem[row_i] <= '{re: value_re_i, im: value_im_i};
        end
      end else begin
        f1_job_q.row     <= row_i;
        f1_job_q.col     <= col_i;
        f1_job_q.elem    <= '{re: value_re_i, im: value_im_i};
        f1_job_q.x_row   <= x_mem[row_i];
        f1_job_q.x_col   <= x_mem[col_i];
        f1_job_q.changed <= changed;
      end
    end
  end

  // staging register always drains; room was checked at accept
  assign q_push_o = f1_valid_q;
  assign q_job_o  = f1_job_q;

endmodule

// ----- rtl/hru_queue.sv -----
// Short queue of classified update items between front and back end.
// Depends on hru_pkg.
`timescale 1ns / 1ps

module hru_queue import hru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  job_t             push_job_i,
  input  logic             pop_i,
  output job_t             pop_job_o,
  output logic             empty_o,
  output logic [QCntW-1:0] count_o
);

  job_t             slots [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? QPtrW'((int'(wr_ptr_q) + 1) % QDepth) : wr_ptr_q;
    rd_ptr_d = do_pop ? QPtrW'((int'(rd_ptr_q) + 1) % QDepth) : rd_ptr_q;
    count_d  = count_q + QCntW'(push_i) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= push_job_i;
    end
  end

  assign pop_job_o = slots[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;

endmodule

// ----- rtl/hru_back.sv -----
// Back end: three-stage multiply and accumulate pipeline feeding the result
// queue, issue gated by credits. Depends on hru_pkg.
`timescale 1ns / 1ps

module hru_back import hru_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q15_t    alpha_i,
  input  logic    q_empty_i,
  input  job_t    q_job_i,
  output logic    q_pop_o,
  input  logic    pop,
  output logic    empty,
  output result_t res_o
);

  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    cplx_t           elem;
    cplx_t           x_row;
    cplx_t           s;
    logic            changed;
  } st1_t;

  typedef struct packed {
    logic [IdxW-1:0]          row;
    logic [IdxW-1:0]          col;
    cplx_t                    elem;
    logic signed [2*CompW-1:0] p_rr;
    logic signed [2*CompW-1:0] p_ii;
    logic signed [2*CompW-1:0] p_ri;
    logic signed [2*CompW-1:0] p_ir;
    logic                     changed;
  } st2_t;

  logic                      b1_valid_q, b2_valid_q;
  st1_t                      b1_q;
  st2_t                      b2_q;
  logic [OCntW-1:0]          credit_q, credit_d;
  logic                      issue;
  logic                      out_pop;
  logic signed [2*CompW-1:0] m_re, m_im;
  logic signed [2*CompW:0]   m_im_neg;
  logic signed [2*CompW:0]   sum_re, sum_im;
  q15_t                      p_re, p_im;
  result_t                   res_d;
  result_t                   o_slots [ODepth];
  logic [OPtrW-1:0]          o_wr_q, o_rd_q;
  logic [OCntW-1:0]          o_cnt_q;

  assign out_pop = pop && !empty;

  // issue only when a place in the result queue is reserved
  assign issue   = !q_empty_i && ((credit_q != OCntW'(ODepth)) || out_pop);
  assign q_pop_o = issue;
  assign credit_d = credit_q + OCntW'(issue) - OCntW'(out_pop);

  // stage 1: s = conj(x[col]) * alpha
  assign m_re     = q_job_i.x_col.re * alpha_i;
  assign m_im     = q_job_i.x_col.im * alpha_i;
  assign m_im_neg = -((2*CompW+1)'(m_im));

  // stage 3: complex sum, floor, add into element; diagonal imaginary part cleared
  always_comb begin
    sum_re = (2*CompW+1)'(b2_q.p_rr) - (2*CompW+1)'(b2_q.p_ii);
    sum_im = (2*CompW+1)'(b2_q.p_ri) + (2*CompW+1)'(b2_q.p_ir);
    p_re   = sat_q15(34'(sum_re >>> (CompW - 1)));
    p_im   = sat_q15(34'(sum_im >>> (CompW - 1)));
    res_d.row     = b2_q.row;
    res_d.col     = b2_q.col;
    res_d.changed = b2_q.changed;
    res_d.elem    = b2_q.elem;
    if (b2_q.changed) begin
      res_d.elem.re = sat_q15(34'(b2_q.elem.re) + 34'(p_re));
      if (b2_q.row == b2_q.col) begin
        res_d.elem.im = '0;
      end else begin
        res_d.elem.im = sat_q15(34'(b2_q.elem.im) + 34'(p_im));
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      credit_q   <= '0;
      o_wr_q     <= '0;
      o_rd_q     <= '0;
      o_cnt_q    <= '0;
    end else begin
      b1_valid_q <= issue;
      b2_valid_q <= b1_valid_q;
      credit_q   <= credit_d;
      if (b2_valid_q) begin
        o_wr_q <= OPtrW'((int'(o_wr_q) + 1) % ODepth);
      end
      if (out_pop) begin
        o_rd_q <= OPtrW'((int'(o_rd_q) + 1) % ODepth);
      end
      o_cnt_q <= o_cnt_q + OCntW'(b2_valid_q) - OCntW'(out_pop);
    end
  end

  // pipeline payload and result storage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_q.row     <= q_job_i.row;
      b1_q.col     <= q_job_i.col;
      b1_q.elem    <= q_job_i.elem;
      b1_q.x_row   <= q_job_i.x_row;
      b1_q.s.re    <= sat_q15(34'(m_re >>> (CompW - 1)));
      b1_q.s.im    <= sat_q15(34'(m_im_neg >>> (CompW - 1)));
      b1_q.changed <= q_job_i.changed;
    end
    if (b1_valid_q) begin
      b2_q.row     <= b1_q.row;
      b2_q.col     <= b1_q.col;
      b2_q.elem    <= b1_q.elem;
      b2_q.p_rr    <= b1_q.s.re * b1_q.x_row.re;
      b2_q.p_ii    <= b1_q.s.im * b1_q.x_row.im;
      b2_q.p_ri    <= b1_q.s.re * b1_q.x_row.im;
      b2_q.p_ir    <= b1_q.s.im * b1_q.x_row.re;
      b2_q.changed <= b1_q.changed;
    end
    if (b2_valid_q) begin
      o_slots[o_wr_q] <= res_d;
    end
  end

  assign empty = (o_cnt_q == '0);
  assign res_o = o_slots[o_rd_q];

endmodule

// ----- rtl/hermitian_rank1_update.sv -----
// Top level of the Hermitian rank-1 update A += alpha*x*x^H on one triangle.
// Holds the configuration registers; uses hru_pkg, hru_front, hru_queue, hru_back.
//
//   channel   direction  handshake              payload
//   input     in         push / full            command, row, col, value_re/im
//   result    out        empty / pop            out_row, out_col, elem_re/im,
//                                               was_changed
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while full stays low. An update passes the x
// store read, the queue, two multiply stages and the result queue before it
// shows on the result ports; a load item gives no result.
// Full rises when the four-entry queue behind the x store backs up; the back
// end issues only with a free place in its four-entry result queue.
// Reset restores the register defaults; the x store is not cleared.
`timescale 1ns / 1ps

module hermitian_rank1_update import hru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               command_i,
  input  logic [IdxW-1:0]    row_i,
  input  logic [IdxW-1:0]    col_i,
  input  q15_t               value_re_i,
  input  q15_t               value_im_i,
  output logic               empty,
  input  logic               pop,
  output logic [IdxW-1:0]    out_row_o,
  output logic [IdxW-1:0]    out_col_o,
  output q15_t               elem_re_o,
  output q15_t               elem_im_o,
  output logic               was_changed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CompW-1:0]   cfg_data_i
);

  cfg_t             cfg_q;
  logic             q_push, q_pop, q_empty;
  job_t             q_push_job, q_pop_job;
  logic [QCntW-1:0] q_count;
  result_t          res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper  <= 1'b1;
      cfg_q.length <= LenW'(MaxN);
      cfg_q.alpha  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_UPPER:  cfg_q.upper  <= cfg_data_i[0];
        CFG_LENGTH: cfg_q.length <= cfg_data_i[LenW-1:0];
        CFG_ALPHA:  cfg_q.alpha  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .command_i  (command_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_re_i (value_re_i),
    .value_im_i (value_im_i),
    .q_count_i  (q_count),
    .q_push_o   (q_push),
    .q_job_o    (q_push_job)
  );

  hru_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_push_job),
    .pop_i      (q_pop),
    .pop_job_o  (q_pop_job),
    .empty_o    (q_empty),
    .count_o    (q_count)
  );

  hru_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .alpha_i   (cfg_q.alpha),
    .q_empty_i (q_empty),
    .q_job_i   (q_pop_job),
    .q_pop_o   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .res_o     (res)
  );

  assign out_row_o     = res.row;
  assign out_col_o     = res.col;
  assign elem_re_o     = res.elem.re;
  assign elem_im_o     = res.elem.im;
  assign was_changed_o = res.changed;

endmodule

// ----- rtl/hru_checker.sv -----
// Port-level checks for the Hermitian rank-1 update block, bound to the top.
// Depends on hru_pkg and hermitian_rank1_update.
`timescale 1ns / 1ps

module hru_props import hru_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               command_i,
  input logic               empty,
  input logic               pop,
  input logic [IdxW-1:0]    out_row_o,
  input logic [IdxW-1:0]    out_col_o,
  input q15_t               elem_re_o,
  input q15_t               elem_im_o,
  input logic               was_changed_o
);

  // an updated diagonal element has its imaginary part cleared
  a_diag_im_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && was_changed_o && (out_row_o == out_col_o)) |-> (elem_im_o == '0))
    else $error("changed diagonal element with nonzero imaginary part");

  // a waiting result stays put until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_row_o) && $stable(out_col_o) &&
                          $stable(elem_re_o) && $stable(elem_im_o) &&
                          $stable(was_changed_o)))
    else $error("waiting result changed or vanished");

  // an accepted update shows a result when nothing is taken and reset stays off
  a_update_arrives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(push && !full && command_i, 5) &&
     $past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) &&
     $past(rst_ni, 4) && $past(rst_ni, 5) &&
     !$past(pop, 1) && !$past(pop, 2) && !$past(pop, 3) &&
     !$past(pop, 4) && !$past(pop, 5)) |-> !empty)
    else $error("update item produced no result in time");

endmodule

bind hermitian_rank1_update hru_props u_hru_props (.*);

// ----- sim/hru_checker.sv -----
// Checker for the Hermitian rank-1 update block: watches the input, result and
// register channels, predicts every returned element and compares it.
// Depends on hru_pkg for field widths, commands, register indexes and item types.
`timescale 1ns / 1ps

module hru_checker import hru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  logic               command_i,
  input  logic [IdxW-1:0]    row_i,
  input  logic [IdxW-1:0]    col_i,
  input  q15_t               value_re_i,
  input  q15_t               value_im_i,
  input  logic               empty,
  input  logic               pop,
  input  logic [IdxW-1:0]    out_row_i,
  input  logic [IdxW-1:0]    out_col_i,
  input  q15_t               elem_re_i,
  input  q15_t               elem_im_i,
  input  logic               was_changed_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CompW-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef logic signed [47:0] wide_t;

  // shadow copy of the x vector and of the registers
  cplx_t   x_shadow [MaxN];
  cfg_t    cfg_shadow;
  result_t expected_elems [$];

  function automatic q15_t clamp_q15(wide_t v);
    q15_t r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CompW-1:0];
    end
    return r;
  endfunction

  // product back to Q1.15: arithmetic shift floors, then clamp
  function automatic q15_t product_to_q15(wide_t prod);
    return clamp_q15(prod >>> (CompW - 1));
  endfunction

  // element (row, col) after A += alpha * x * x^H on the chosen triangle
  function automatic result_t updated_elem(logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                                           cplx_t elem);
    int      n;
    cplx_t   xr;
    cplx_t   xc;
    wide_t   alpha_w;
    q15_t    s_re;
    q15_t    s_im;
    q15_t    p_re;
    q15_t    p_im;
    logic    in_triangle;
    result_t res;
    n = (int'(cfg_shadow.length) < MaxN) ? int'(cfg_shadow.length) : MaxN;
    in_triangle = (row == col) || (cfg_shadow.upper ? (row < col) : (row > col));
    res.row     = row;
    res.col     = col;
    res.elem    = elem;
    res.changed = 1'b0;
    if (cfg_shadow.alpha != 0 && int'(row) < n && int'(col) < n && in_triangle) begin
      xr      = x_shadow[row];
      xc      = x_shadow[col];
      alpha_w = wide_t'($signed(cfg_shadow.alpha));
      // s = conj(x[col]) * alpha
      s_re = product_to_q15(wide_t'($signed(xc.re)) * alpha_w);
      s_im = product_to_q15(-wide_t'($signed(xc.im)) * alpha_w);
      // p = s * x[row], each sum exact before the one floor
      p_re = product_to_q15(wide_t'($signed(s_re)) * wide_t'($signed(xr.re))
                          - wide_t'($signed(s_im)) * wide_t'($signed(xr.im)));
      p_im = product_to_q15(wide_t'($signed(s_re)) * wide_t'($signed(xr.im))
                          + wide_t'($signed(s_im)) * wide_t'($signed(xr.re)));
      res.elem.re = clamp_q15(wide_t'($signed(elem.re)) + wide_t'($signed(p_re)));
      res.elem.im = (row == col) ? '0
                  : clamp_q15(wide_t'($signed(elem.im)) + wide_t'($signed(p_im)));
      res.changed = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    cplx_t   item_val;
    if (!rst_ni) begin
      cfg_shadow.upper  = 1'b1;
      cfg_shadow.length = LenW'(MaxN);
      cfg_shadow.alpha  = '0;
      expected_elems.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // returned element against the oldest prediction
      if (pop && !empty) begin
        if (expected_elems.size() == 0) begin
          fail_count_o++;
          $display("%0t: element (%0d,%0d) returned with nothing expected",
                   $time, out_row_i, out_col_i);
        end else begin
          want = expected_elems.pop_front();
          check_field("out_row", int'(want.row), int'(out_row_i));
          check_field("out_col", int'(want.col), int'(out_col_i));
          check_field("elem_re", int'($signed(want.elem.re)), int'(elem_re_i));
          check_field("elem_im", int'($signed(want.elem.im)), int'(elem_im_i));
          check_field("was_changed", int'(want.changed), int'(was_changed_i));
        end
      end
      // accepted item: load into the shadow store or predict an element
      if (push && !full) begin
        item_val.re = value_re_i;
        item_val.im = value_im_i;
        if (command_i == CMD_LOAD) begin
          x_shadow[row_i] = item_val;
        end else begin
          expected_elems.push_back(updated_elem(row_i, col_i, item_val));
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_UPPER:  cfg_shadow.upper  = cfg_data_i[0];
          CFG_LENGTH: cfg_shadow.length = cfg_data_i[LenW-1:0];
          CFG_ALPHA:  cfg_shadow.alpha  = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_elems.size();
    end
  end

endmodule

// ----- sim/hermitian_rank1_update_tb.sv -----
// Testbench top for hermitian_rank1_update: clock, reset, stimulus through
// register phases, receiver stalls and the verdict; hru_checker does the checking.
// Depends on hru_pkg, hermitian_rank1_update and hru_checker.
`timescale 1ns / 1ps

module hermitian_rank1_update_tb;
  import hru_pkg::*;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 100;
  localparam int DrainCycles   = 12;
  localparam int HoldCycles    = 80;
  localparam int TimeoutNs     = 5_000_000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               push        = 1'b0;
  logic               full;
  logic               command_i   = CMD_LOAD;
  logic [IdxW-1:0]    row_i       = '0;
  logic [IdxW-1:0]    col_i       = '0;
  q15_t               value_re_i  = '0;
  q15_t               value_im_i  = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [IdxW-1:0]    out_row_o;
  logic [IdxW-1:0]    out_col_o;
  q15_t               elem_re_o;
  q15_t               elem_im_o;
  logic               was_changed_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_UPPER;
  logic [CompW-1:0]   cfg_data_i  = '0;

  int mismatch_count;
  int elems_in_flight;

  // x entries loaded so far; updates only ever read these
  bit              x_loaded [MaxN];
  logic [IdxW-1:0] loaded_idx [$];

  bit hold_off_req = 1'b0;

  hermitian_rank1_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .command_i     (command_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_re_i    (value_re_i),
    .value_im_i    (value_im_i),
    .empty         (empty),
    .pop           (pop),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .elem_re_o     (elem_re_o),
    .elem_im_o     (elem_im_o),
    .was_changed_o (was_changed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  hru_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .command_i     (command_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .value_re_i    (value_re_i),
    .value_im_i    (value_im_i),
    .empty         (empty),
    .pop           (pop),
    .out_row_i     (out_row_o),
    .out_col_i     (out_col_o),
    .elem_re_i     (elem_re_o),
    .elem_im_i     (elem_im_o),
    .was_changed_i (was_changed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (mismatch_count),
    .pending_o     (elems_in_flight)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop
  initial begin
    #(TimeoutNs);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic q15_t rand_q15();
    q15_t v;
    case ($urandom_range(0, 9))
      0:       v = 16'sh7fff;
      1:       v = 16'sh8000;
      2:       v = '0;
      3:       v = -16'sd1;
      default: v = q15_t'($urandom);
    endcase
    return v;
  endfunction

  // an index already loaded, biased to fall below n
  function automatic logic [IdxW-1:0] pick_loaded(int n);
    logic [IdxW-1:0] cand;
    for (int t = 0; t < 8; t++) begin
      cand = ($urandom_range(0, 1) && n > 0) ? IdxW'($urandom_range(0, n - 1))
                                            : IdxW'($urandom);
      if (x_loaded[cand]) return cand;
    end
    return loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
  endfunction

  // offer one item at the falling edge, return once it is taken
  task automatic send_item(cmd_e cmd, logic [IdxW-1:0] row, logic [IdxW-1:0] col,
                           q15_t re, q15_t im);
    @(negedge clk_i);
    push       <= 1'b1;
    command_i  <= cmd;
    row_i      <= row;
    col_i      <= col;
    value_re_i <= re;
    value_im_i <= im;
    if (cmd == CMD_LOAD && !x_loaded[row]) begin
      x_loaded[row] = 1'b1;
      loaded_idx.push_back(row);
    end
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CompW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering, wait for every predicted element, then let loads settle
  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (elems_in_flight != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // receiver: rotating stall patterns plus the requested long hold-off
  initial begin
    int rx_cycle;
    int hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldCycles - 1;
        pop <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= (rx_cycle % 4 == 0);
          default: pop <= (rx_cycle % 16 >= 10);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    cfg_t setting;
    int   n_eff;
    int   burst_left;
    int   gap;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       setting = '{upper: 1'b1, length: 9'd256, alpha: 16'sh7fff};
        1:       setting = '{upper: 1'b0, length: 9'd256, alpha: 16'sh8000};
        2:       setting = '{upper: 1'b1, length: 9'd0,   alpha: -16'sd1000};
        3:       setting = '{upper: 1'b0, length: 9'd1,   alpha: 16'sd1};
        4:       setting = '{upper: 1'b1, length: 9'd255, alpha: -16'sd1};
        5:       setting = '{upper: 1'b0, length: 9'd17,  alpha: 16'sd0};
        6:       setting = '{upper: 1'b1, length: 9'd100, alpha: q15_t'($urandom)};
        default: setting = '{upper: 1'b0, length: 9'd256, alpha: q15_t'($urandom)};
      endcase
      if (setting.alpha == 0 && ph != 5) setting.alpha = 16'sd12345;
      n_eff = (int'(setting.length) < MaxN) ? int'(setting.length) : MaxN;

      wait_idle();
      write_reg(CFG_UPPER,  CompW'(setting.upper));
      write_reg(CFG_LENGTH, CompW'(setting.length));
      write_reg(CFG_ALPHA,  setting.alpha);

      if (ph == 0) begin
        // corner entries of x, loads carry a junk column
        send_item(CMD_LOAD, 8'h00, 8'hff, 16'sh7fff, 16'sh8000);
        send_item(CMD_LOAD, 8'hff, 8'h00, 16'sh8000, 16'sh7fff);
        send_item(CMD_LOAD, 8'h01, 8'h5a, 16'sh8000, 16'sh8000);
        send_item(CMD_LOAD, 8'h55, 8'ha5, 16'sh7fff, 16'sh7fff);
        send_item(CMD_LOAD, 8'haa, 8'h33, 16'sh0000, 16'sh0000);
        // diagonal: real part saturates, imaginary cleared
        send_item(CMD_UPDATE, 8'h00, 8'h00, 16'sh7fff, 16'sh7fff);
        send_item(CMD_UPDATE, 8'hff, 8'hff, 16'sh8000, 16'sh8000);
        send_item(CMD_UPDATE, 8'h01, 8'h01, 16'sh8000, 16'sh0000);
        send_item(CMD_UPDATE, 8'h55, 8'h55, 16'sh0000, 16'sh0000);
        // upper triangle, positive and negative saturation
        send_item(CMD_UPDATE, 8'h00, 8'hff, 16'sh7fff, 16'sh7fff);
        send_item(CMD_UPDATE, 8'h01, 8'hff, 16'sh8000, 16'sh8000);
        send_item(CMD_UPDATE, 8'h55, 8'haa, 16'sh1234, -16'sh1234);
        // lower triangle passes unchanged
        send_item(CMD_UPDATE, 8'hff, 8'h00, 16'sh7fff, 16'sh8000);
        send_item(CMD_UPDATE, 8'haa, 8'h55, -16'sd1, 16'sd1);
      end

      // random items in bursts with gaps
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            @(negedge clk_i);
            push <= 1'b0;
            repeat (gap - 1) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        // long receiver hold-off while items keep coming
        if ((ph == 0 || ph == NumPhases - 1) && i == 40) hold_off_req = 1'b1;
        if ($urandom_range(0, 9) < 3) begin
          send_item(CMD_LOAD,
                    ($urandom_range(0, 1) && n_eff > 0) ? IdxW'($urandom_range(0, n_eff - 1))
                                                        : IdxW'($urandom),
                    IdxW'($urandom), rand_q15(), rand_q15());
        end else begin
          send_item(CMD_UPDATE, pick_loaded(n_eff), pick_loaded(n_eff),
                    rand_q15(), rand_q15());
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
